/* src/asef_pkg.sv */
package asef_pkg;

  // field widths
  localparam int unsigned RawW     = 16;
  localparam int unsigned EngW     = 32;
  localparam int unsigned AlphaW   = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OutDataW = 3 * EngW;

  // q1.16 weight
  localparam int unsigned           AlphaFracW = 16;
  localparam logic [AlphaW-1:0]     AlphaOne   = AlphaW'(1 << AlphaFracW);
  localparam int unsigned           RoundBias  = (1 << AlphaFracW) - 1;

  // scaling datapath
  localparam int unsigned DiffW    = RawW + 1;      // raw difference, signed
  localparam int unsigned EngDiffW = EngW + 1;      // engineering span, signed
  localparam int unsigned MagW     = RawW + EngW;   // product magnitude
  localparam int unsigned ScaleSumW = MagW + 2;     // eng_low plus signed quotient
  localparam int unsigned BlendW   = AlphaW + 1 + EngW;

  // serial divider
  localparam int unsigned DivBitsPerStep = 2;
  localparam int unsigned DivSteps       = MagW / DivBitsPerStep;
  localparam int unsigned DivCntW        = $clog2(DivSteps);

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRawLow  = 3'd0,
    CfgRawHigh = 3'd1,
    CfgEngLow  = 3'd2,
    CfgEngHigh = 3'd3,
    CfgWeight  = 3'd4
  } cfg_idx_e;

  // one classified sample, front to back
  typedef struct packed {
    logic [RawW-1:0]        num_mag;
    logic [RawW-1:0]        span_mag;
    logic [EngW-1:0]        eng_mag;
    logic                   neg;
    logic                   zero_span;
    logic signed [EngW-1:0] eng_low;
    logic [AlphaW-1:0]      alpha;
  } asef_item_t;

  typedef enum logic [2:0] {
    BackIdle,
    BackMul,
    BackDiv,
    BackScale,
    BackBlend,
    BackAvg,
    BackOut
  } back_state_e;

endpackage

/* src/asef_front.sv */
module asef_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [asef_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [asef_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            raw_valid_i,
  output logic                            raw_ready_o,
  input  logic [asef_pkg::RawW-1:0]       raw_sample_i,
  output logic                            item_valid_o,
  input  logic                            item_ready_i,
  output asef_pkg::asef_item_t            item_o
);

  logic signed [asef_pkg::RawW-1:0]   raw_low_q, raw_high_q;
  logic signed [asef_pkg::EngW-1:0]   eng_low_q, eng_high_q;
  logic        [asef_pkg::AlphaW-1:0] weight_q;

  logic [asef_pkg::DiffW-1:0]    num, span, num_n, span_n;
  logic [asef_pkg::EngDiffW-1:0] eng_diff, eng_diff_n;

  assign cfg_ready_o  = 1'b1;
  assign item_valid_o = raw_valid_i;
  assign raw_ready_o  = item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_low_q  <= '0;
      raw_high_q <= asef_pkg::RawW'(32767);
      eng_low_q  <= '0;
      eng_high_q <= asef_pkg::EngW'(65536);
      weight_q   <= asef_pkg::AlphaOne;
    end else if (cfg_valid_i) begin
      case (asef_pkg::cfg_idx_e'(cfg_index_i))
        asef_pkg::CfgRawLow:  raw_low_q  <= cfg_data_i[asef_pkg::RawW-1:0];
        asef_pkg::CfgRawHigh: raw_high_q <= cfg_data_i[asef_pkg::RawW-1:0];
        asef_pkg::CfgEngLow:  eng_low_q  <= cfg_data_i[asef_pkg::EngW-1:0];
        asef_pkg::CfgEngHigh: eng_high_q <= cfg_data_i[asef_pkg::EngW-1:0];
        asef_pkg::CfgWeight:  weight_q   <= cfg_data_i[asef_pkg::AlphaW-1:0];
        default: ;
      endcase
    end
  end

  // sign-extended differences, then magnitudes and the quotient sign
  always_comb begin
    num      = {raw_sample_i[asef_pkg::RawW-1], raw_sample_i}
             - {raw_low_q[asef_pkg::RawW-1], raw_low_q};
    span     = {raw_high_q[asef_pkg::RawW-1], raw_high_q}
             - {raw_low_q[asef_pkg::RawW-1], raw_low_q};
    eng_diff = {eng_high_q[asef_pkg::EngW-1], eng_high_q}
             - {eng_low_q[asef_pkg::EngW-1], eng_low_q};
    num_n      = ~num + 1'b1;
    span_n     = ~span + 1'b1;
    eng_diff_n = ~eng_diff + 1'b1;

    item_o.num_mag   = num[asef_pkg::DiffW-1] ? num_n[asef_pkg::RawW-1:0]
                                              : num[asef_pkg::RawW-1:0];
    item_o.span_mag  = span[asef_pkg::DiffW-1] ? span_n[asef_pkg::RawW-1:0]
                                               : span[asef_pkg::RawW-1:0];
    item_o.eng_mag   = eng_diff[asef_pkg::EngDiffW-1] ? eng_diff_n[asef_pkg::EngW-1:0]
                                                      : eng_diff[asef_pkg::EngW-1:0];
    item_o.neg       = num[asef_pkg::DiffW-1] ^ span[asef_pkg::DiffW-1]
                     ^ eng_diff[asef_pkg::EngDiffW-1];
    item_o.zero_span = (raw_high_q == raw_low_q);
    item_o.eng_low   = eng_low_q;
    item_o.alpha     = (weight_q > asef_pkg::AlphaOne) ? asef_pkg::AlphaOne : weight_q;
  end

endmodule

/* src/asef_fifo.sv */
module asef_fifo #(
  parameter int unsigned Depth = asef_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  asef_pkg::asef_item_t push_item_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output asef_pkg::asef_item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  asef_pkg::asef_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* src/asef_back.sv */
module asef_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  output logic                         item_ready_o,
  input  asef_pkg::asef_item_t         item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [asef_pkg::EngW-1:0]    scaled_value_o,
  output logic [asef_pkg::EngW-1:0]    smoothed_value_o,
  output logic [asef_pkg::EngW-1:0]    change_rate_o
);

  localparam int unsigned EngW = asef_pkg::EngW;
  localparam int unsigned MagW = asef_pkg::MagW;
  localparam int unsigned DivW = asef_pkg::RawW;
  localparam int unsigned SumW = asef_pkg::ScaleSumW;
  localparam int unsigned BlendW = asef_pkg::BlendW;
  localparam int unsigned AccW = BlendW + 1;

  asef_pkg::back_state_e state_q, state_d;
  asef_pkg::asef_item_t  item_q;

  logic [MagW-1:0]              quot_q, quot_d;
  logic [DivW-1:0]              rem_q, rem_d;
  logic [asef_pkg::DivCntW-1:0] cnt_q;
  logic signed [EngW-1:0]       scaled_q, scaled_d, prev_q, smoothed_q, smoothed_d;
  logic signed [EngW-1:0]       change_q, change_d;
  logic signed [BlendW-1:0]     pa_q, pb_q, pa_d, pb_d;

  logic [DivW:0]                trial;
  logic [MagW:0]                q_ext, q_sgn;
  logic [SumW-1:0]              scale_sum;
  logic signed [asef_pkg::AlphaW:0] a_s, b_s;
  logic [AccW-1:0]              acc, acc_adj;
  logic [EngW:0]                diff;
  logic                         div_last;

  assign div_last = (cnt_q == asef_pkg::DivCntW'(asef_pkg::DivSteps - 1));

  // two restoring division steps per cycle
  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    trial  = '0;
    for (int i = 0; i < asef_pkg::DivBitsPerStep; i++) begin
      trial  = {rem_d, quot_d[MagW-1]};
      quot_d = {quot_d[MagW-2:0], 1'b0};
      if (trial >= {1'b0, item_q.span_mag}) begin
        rem_d     = DivW'(trial - {1'b0, item_q.span_mag});
        quot_d[0] = 1'b1;
      end else begin
        rem_d = trial[DivW-1:0];
      end
    end
  end

  // signed quotient plus offset, saturated
  always_comb begin
    q_ext     = {1'b0, quot_q};
    q_sgn     = item_q.neg ? (~q_ext + 1'b1) : q_ext;
    scale_sum = {{(SumW-EngW){item_q.eng_low[EngW-1]}}, item_q.eng_low}
              + {{(SumW-MagW-1){q_sgn[MagW]}}, q_sgn};
    if (scale_sum[SumW-1:EngW-1] == '0 || scale_sum[SumW-1:EngW-1] == '1) begin
      scaled_d = scale_sum[EngW-1:0];
    end else if (scale_sum[SumW-1]) begin
      scaled_d = {1'b1, {(EngW-1){1'b0}}};
    end else begin
      scaled_d = {1'b0, {(EngW-1){1'b1}}};
    end
  end

  // weighted products
  always_comb begin
    a_s  = $signed({1'b0, item_q.alpha});
    b_s  = $signed({1'b0, asef_pkg::AlphaOne - item_q.alpha});
    pa_d = a_s * scaled_q;
    pb_d = b_s * prev_q;
  end

  // blend, truncate toward zero, change saturated
  always_comb begin
    acc     = {pa_q[BlendW-1], pa_q} + {pb_q[BlendW-1], pb_q};
    acc_adj = acc + (acc[AccW-1] ? AccW'(asef_pkg::RoundBias) : '0);
    smoothed_d = acc_adj[asef_pkg::AlphaFracW +: EngW];
    diff = {smoothed_d[EngW-1], smoothed_d} - {prev_q[EngW-1], prev_q};
    if (diff[EngW] == diff[EngW-1]) begin
      change_d = diff[EngW-1:0];
    end else if (diff[EngW]) begin
      change_d = {1'b1, {(EngW-1){1'b0}}};
    end else begin
      change_d = {1'b0, {(EngW-1){1'b1}}};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      asef_pkg::BackIdle:  if (item_valid_i) state_d = asef_pkg::BackMul;
      asef_pkg::BackMul:   state_d = item_q.zero_span ? asef_pkg::BackBlend : asef_pkg::BackDiv;
      asef_pkg::BackDiv:   if (div_last) state_d = asef_pkg::BackScale;
      asef_pkg::BackScale: state_d = asef_pkg::BackBlend;
      asef_pkg::BackBlend: state_d = asef_pkg::BackAvg;
      asef_pkg::BackAvg:   state_d = asef_pkg::BackOut;
      asef_pkg::BackOut:   if (out_ready_i) state_d = asef_pkg::BackIdle;
      default:             state_d = asef_pkg::BackIdle;
    endcase
  end

  always_comb begin
    item_ready_o = (state_q == asef_pkg::BackIdle);
    out_valid_o  = (state_q == asef_pkg::BackOut);
  end

  assign scaled_value_o   = scaled_q;
  assign smoothed_value_o = smoothed_q;
  assign change_rate_o    = change_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asef_pkg::BackIdle;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == asef_pkg::BackAvg) begin
        prev_q <= smoothed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      asef_pkg::BackIdle: begin
        if (item_valid_i) item_q <= item_i;
      end
      asef_pkg::BackMul: begin
        quot_q   <= item_q.num_mag * item_q.eng_mag;
        rem_q    <= '0;
        cnt_q    <= '0;
        scaled_q <= '0;
      end
      asef_pkg::BackDiv: begin
        quot_q <= quot_d;
        rem_q  <= rem_d;
        cnt_q  <= cnt_q + 1'b1;
      end
      asef_pkg::BackScale: scaled_q <= scaled_d;
      asef_pkg::BackBlend: begin
        pa_q <= pa_d;
        pb_q <= pb_d;
      end
      asef_pkg::BackAvg: begin
        smoothed_q <= smoothed_d;
        change_q   <= change_d;
      end
      asef_pkg::BackOut: ;
      default: ;
    endcase
  end

endmodule

/* src/analog_scale_ema_filter_top.sv */
// analog channel scaler with exponential moving average
//
// channels: s_axis carries one raw converter word per sample, m_axis returns one
// result word per sample (scaled, smoothed and change, all q16.16), and the cfg
// write channel sets span and weight registers by index; cfg_ready_o is always
// high; the user must let writes go in only while no sample is in flight, and the
// block itself does not enforce it
//
// a sample accepted on s_axis into an idle block passes the queue, then the back
// end steps through multiply, serial divide, scale, blend, average and output
// states, skipping divide and scale when the raw span is zero; the serial divider
// (two quotient bits a cycle for the 48 bit product) sets the bulk of the time;
// the back end takes the next sample only once its result is taken on m_axis
//
// a front stage classifies each sample against the live registers and hands
// it through a short queue, so s_axis keeps accepting while the back end
// divides or while a result waits on m_axis_tready; when the queue fills,
// s_axis_tready drops
// reset: registers return to their defaults, the queue empties and the
// running average starts at zero
module analog_scale_ema_filter_top #(
  parameter int unsigned QueueDepth = asef_pkg::QueueDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [asef_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [asef_pkg::CfgDataW-1:0]  cfg_data_i,
  // sample input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [asef_pkg::RawW-1:0]      s_axis_tdata,  // raw_sample[15:0]
  // result output
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // scaled_value[31:0], smoothed_value[63:32], change_rate[95:64]
  output logic [asef_pkg::OutDataW-1:0]  m_axis_tdata
);

  // classified word on its way to the queue, and at the queue head
  asef_pkg::asef_item_t front_item, head_item;
  logic front_valid, front_ready, head_valid, head_ready;
  logic [asef_pkg::EngW-1:0] scaled, smoothed, change;

  asef_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .raw_valid_i  (s_axis_tvalid),
    .raw_ready_o  (s_axis_tready),
    .raw_sample_i (s_axis_tdata),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item)
  );

  // decouples classification from the divider
  asef_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready),
    .pop_item_o   (head_item)
  );

  // multiply, serial divide, saturate, blend; result held until taken
  asef_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (head_valid),
    .item_ready_o     (head_ready),
    .item_i           (head_item),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .scaled_value_o   (scaled),
    .smoothed_value_o (smoothed),
    .change_rate_o    (change)
  );

  assign m_axis_tdata = {change, smoothed, scaled};

endmodule

/* src/asef_checker.sv */
module asef_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [asef_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned EngW = asef_pkg::EngW;

  logic signed [EngW-1:0] last_q, scaled, smoothed, change, change_exp;
  logic [EngW:0] diff;
  logic out_word;

  assign out_word = m_axis_tvalid && m_axis_tready;
  assign scaled   = m_axis_tdata[EngW-1:0];
  assign smoothed = m_axis_tdata[2*EngW-1:EngW];
  assign change   = m_axis_tdata[3*EngW-1:2*EngW];

  always_comb begin
    diff = {smoothed[EngW-1], smoothed} - {last_q[EngW-1], last_q};
    if (diff[EngW] == diff[EngW-1]) begin
      change_exp = diff[EngW-1:0];
    end else if (diff[EngW]) begin
      change_exp = {1'b1, {(EngW-1){1'b0}}};
    end else begin
      change_exp = {1'b0, {(EngW-1){1'b1}}};
    end
  end

  // smoothed value of the last word delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (out_word) begin
      last_q <= smoothed;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_word |-> change == change_exp)
    else $error("change does not match the step in the average");

  a_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_word |-> (smoothed >= scaled && smoothed <= last_q)
              || (smoothed <= scaled && smoothed >= last_q))
    else $error("average left the span of its inputs");

endmodule

bind analog_scale_ema_filter_top asef_checker u_asef_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* verif/analog_scale_ema_filter_top_tb.sv */
module analog_scale_ema_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asef_pkg::*;

  localparam int unsigned HalfPeriodNs = 6;
  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned RandomItems  = 1850;
  localparam int unsigned MaxReports   = 200;

  localparam logic signed [RawW-1:0] RawMin = 16'sh8000;
  localparam logic signed [RawW-1:0] RawMax = 16'sh7fff;
  localparam logic signed [EngW-1:0] EngMin = 32'sh8000_0000;
  localparam logic signed [EngW-1:0] EngMax = 32'sh7fff_ffff;
  localparam longint                 Unity  = longint'(AlphaOne);

  // register indexes above the weight decode to nothing
  localparam logic [CfgIdxW-1:0] FirstSpareIdx = CfgIdxW'(CfgWeight + 1);

  // result word layout, lowest field last
  typedef struct packed {
    logic signed [EngW-1:0] change;
    logic signed [EngW-1:0] smoothed;
    logic signed [EngW-1:0] scaled;
  } ema_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i   = '0;
  logic [CfgDataW-1:0]   cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [RawW-1:0]       s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;

  // shadow of the register file and the running average
  logic signed [RawW-1:0] raw_low_q   = '0;
  logic signed [RawW-1:0] raw_high_q  = RawMax;
  logic signed [EngW-1:0] eng_low_q   = '0;
  logic signed [EngW-1:0] eng_high_q  = EngW'(Unity);
  logic [AlphaW-1:0]      weight_q    = AlphaOne;
  logic signed [EngW-1:0] running_avg = '0;

  ema_result_t expected_results[$];
  int unsigned mismatch_count = 0;
  bit          input_steady   = 1'b0;

  analog_scale_ema_filter_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin : clock_gen
    forever #(HalfPeriodNs) clk_i = ~clk_i;
  end

  initial begin : reset_gen
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : watchdog
    #25ms;
    $display("analog_scale_ema_filter_top regression: fail");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic longint clamp32(longint x);
    if (x > longint'(EngMax)) return longint'(EngMax);
    if (x < longint'(EngMin)) return longint'(EngMin);
    return x;
  endfunction

  // scale one raw sample, blend it into the average and advance the average
  function automatic ema_result_t predict_sample(logic [RawW-1:0] raw);
    longint      span;
    longint      prod;
    longint      scaled;
    longint      alpha;
    longint      avg_new;
    ema_result_t res;
    span   = longint'(raw_high_q) - longint'(raw_low_q);
    scaled = 0;
    if (span != 0) begin
      prod   = (longint'($signed(raw)) - longint'(raw_low_q)) *
               (longint'(eng_high_q) - longint'(eng_low_q));
      scaled = clamp32(longint'(eng_low_q) + prod / span);
    end
    alpha   = (weight_q > AlphaOne) ? Unity : longint'(weight_q);
    // signed division truncates toward zero
    avg_new = (alpha * scaled + (Unity - alpha) * longint'(running_avg)) / Unity;
    res.scaled   = EngW'(scaled);
    res.smoothed = EngW'(avg_new);
    res.change   = EngW'(clamp32(avg_new - longint'(running_avg)));
    running_avg  = EngW'(avg_new);
    return res;
  endfunction

  function automatic void apply_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgRawLow:  raw_low_q  = data[RawW-1:0];
      CfgRawHigh: raw_high_q = data[RawW-1:0];
      CfgEngLow:  eng_low_q  = data[EngW-1:0];
      CfgEngHigh: eng_high_q = data[EngW-1:0];
      CfgWeight:  weight_q   = data[AlphaW-1:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) $display("%0t mismatch: %s", $time, msg);
  endtask

  // valid stays high across back to back writes; cfg_release lowers it
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, data);
  endtask

  task automatic cfg_release();
    cfg_valid_i <= 1'b0;
  endtask

  // unused upper bits of the narrow registers carry random junk
  task automatic apply_settings(logic signed [RawW-1:0] lo, logic signed [RawW-1:0] hi,
                                logic signed [EngW-1:0] elo, logic signed [EngW-1:0] ehi,
                                logic [AlphaW-1:0] w);
    cfg_write(CfgRawLow,  {16'($urandom), lo});
    cfg_write(CfgRawHigh, {16'($urandom), hi});
    cfg_write(CfgEngLow,  elo);
    cfg_write(CfgEngHigh, ehi);
    cfg_write(CfgWeight,  {15'($urandom), w});
    cfg_release();
  endtask

  task automatic write_spare_indexes();
    for (int i = FirstSpareIdx; i < 2 ** CfgIdxW; i++) begin
      cfg_write(CfgIdxW'(i), $urandom);
    end
    cfg_release();
  endtask

  task automatic send_sample(logic [RawW-1:0] raw);
    int unsigned gap;
    gap = input_steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(predict_sample(raw));
  endtask

  task automatic stop_samples();
    s_axis_tvalid <= 1'b0;
  endtask

  // wait for every word to come back, then let the back end settle
  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // receiver side: runs of ready, some of them long, broken by stalls
  initial begin : ready_gen
    int unsigned run;
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40);
      repeat (run) @(posedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    ema_result_t got;
    ema_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result word with none pending: %h", m_axis_tdata));
      end else begin
        want = expected_results.pop_front();
        if (got.scaled !== want.scaled)
          report_mismatch($sformatf("scaled_value got %0d want %0d", got.scaled, want.scaled));
        if (got.smoothed !== want.smoothed)
          report_mismatch($sformatf("smoothed_value got %0d want %0d",
                                    got.smoothed, want.smoothed));
        if (got.change !== want.change)
          report_mismatch($sformatf("change_rate got %0d want %0d", got.change, want.change));
      end
    end
  end

  // reset defaults: 0..32767 maps onto 0..1.0, weight one
  task automatic test_default_scaling();
    send_sample(RawMin);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(16'sd16384);
    send_sample(RawMax);
    stop_samples();
    drain();
  endtask

  // zero raw span gives a zero scaled value, the average still moves toward it
  task automatic test_zero_span();
    apply_settings(16'sd100, 16'sd100, EngMin, EngMax, 17'd32768);
    send_sample(16'sd100);
    send_sample(RawMin);
    send_sample(RawMax);
    stop_samples();
    drain();
  endtask

  // extrapolation far outside a one-count span saturates both ways,
  // and the jump between the rails saturates the change too
  task automatic test_saturation();
    apply_settings(16'sd0, 16'sd1, 32'sd0, EngMax, 17'h1ffff);
    send_sample(RawMax);
    send_sample(RawMin);
    send_sample(16'sd1);
    stop_samples();
    drain();
    // reversed raw span over the full engineering range
    apply_settings(RawMax, RawMin, EngMin, EngMax, AlphaOne);
    send_sample(RawMin);
    send_sample(RawMax);
    stop_samples();
    drain();
  endtask

  // weight zero holds the average, a tiny weight creeps, above one acts as one
  task automatic test_weight_extremes();
    apply_settings(RawMin, RawMax, -32'sd6553600, 32'sd6553600, 17'd0);
    send_sample(RawMax);
    send_sample(RawMin);
    stop_samples();
    drain();
    apply_settings(RawMin, RawMax, -32'sd6553600, 32'sd6553600, 17'd1);
    send_sample(RawMax);
    send_sample(RawMax);
    stop_samples();
    drain();
    apply_settings(RawMin, RawMax, -32'sd6553600, 32'sd6553600, 17'd65537);
    send_sample(16'sd12345);
    stop_samples();
    drain();
  endtask

  // writes to indexes past the weight must leave the registers untouched
  task automatic test_spare_indexes();
    write_spare_indexes();
    send_sample(-16'sd777);
    send_sample(16'sd2024);
    stop_samples();
    drain();
  endtask

  task automatic randomise_settings();
    logic signed [RawW-1:0] lo;
    logic signed [RawW-1:0] hi;
    logic signed [EngW-1:0] elo;
    logic signed [EngW-1:0] ehi;
    logic [AlphaW-1:0]      w;
    int                     base;
    case ($urandom_range(0, 9))
      0, 1: begin lo = RawMin; hi = RawMax; end
      2:    begin lo = RawMax; hi = RawMin; end
      3, 4: begin
        base = $urandom_range(0, 65535 - 8) - 32768;
        lo = RawW'(base);
        hi = RawW'(base + int'($urandom_range(1, 8)));
        if ($urandom_range(0, 1) == 1) begin lo = hi; hi = RawW'(base); end
      end
      5:    begin lo = RawW'($urandom); hi = lo; end
      default: begin lo = RawW'($urandom); hi = RawW'($urandom); end
    endcase
    case ($urandom_range(0, 5))
      0:    begin elo = EngMin; ehi = EngMax; end
      1:    begin elo = EngMax; ehi = EngMin; end
      2:    begin
        elo = EngW'(-int'($urandom_range(0, 100)) * int'(Unity));
        ehi = EngW'(int'($urandom_range(0, 100)) * int'(Unity));
      end
      3:    begin elo = EngW'($urandom); ehi = elo; end
      default: begin elo = EngW'($urandom); ehi = EngW'($urandom); end
    endcase
    case ($urandom_range(0, 9))
      0:    w = '0;
      1:    w = AlphaOne;
      2:    w = '1;
      3:    w = AlphaOne + 17'd1;
      4:    w = AlphaW'($urandom_range(1, 64));
      5:    w = AlphaW'($urandom_range(0, 131071));
      default: w = AlphaW'($urandom_range(0, 65536));
    endcase
    apply_settings(lo, hi, elo, ehi, w);
    // let valid drop before it rises again, so it is not lowered and raised at the same edge
    if ($urandom_range(0, 7) == 0) begin
      @(posedge clk_i);
      write_spare_indexes();
    end
  endtask

  // mostly inside the raw span, some anywhere, some on the span ends and rails
  function automatic logic [RawW-1:0] random_sample();
    int lo;
    int hi;
    int tmp;
    int unsigned roll;
    lo = raw_low_q;
    hi = raw_high_q;
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) return RawW'(lo + int'($urandom_range(0, hi - lo)));
    if (roll < 85) return RawW'($urandom);
    case ($urandom_range(0, 3))
      0:       return RawW'(lo);
      1:       return RawW'(hi);
      2:       return RawMin;
      default: return RawMax;
    endcase
  endfunction

  task automatic test_random_phases();
    int unsigned sent;
    int unsigned count;
    sent = 0;
    while (sent < RandomItems) begin
      randomise_settings();
      count        = $urandom_range(20, 80);
      input_steady = ($urandom_range(0, 3) == 0);
      repeat (count) send_sample(random_sample());
      stop_samples();
      drain();
      sent += count;
    end
    input_steady = 1'b0;
  endtask

  initial begin : stimulus
    wait (rst_ni);
    @(posedge clk_i);
    test_default_scaling();
    test_zero_span();
    test_saturation();
    test_weight_extremes();
    test_spare_indexes();
    test_random_phases();
    drain();
    if (mismatch_count == 0) begin
      $display("analog_scale_ema_filter_top regression: pass");
    end else begin
      $display("analog_scale_ema_filter_top regression: fail");
    end
    $finish;
  end

endmodule
